@@ hdl/rc4_stream_cipher_macros.svh @@
// assertion macros shared by the rc4 checker
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RC4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rc4 checker: same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define RC4_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rc4 checker: next-cycle implication failed");

`endif

@@ hdl/rc4_pkg.sv @@
// rc4 engine types, constants and microcode table
package rc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 9;
    localparam logic [LEN_W-1:0]  KEY_LEN_RESET = 9'd16;
    localparam logic [BYTE_W-1:0] SB_LAST       = 8'(SBOX_DEPTH - 1);

    // request opcodes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SCHED = 2'd1,
        OP_CRYPT = 2'd2
    } t_opcode;

    // microcode steps
    typedef enum logic [4:0] {
        UPC_IDLE,
        UPC_RFILL,
        UPC_RDONE,
        UPC_SCLR,
        UPC_SFILL,
        UPC_P0,
        UPC_P1,
        UPC_P2,
        UPC_P3,
        UPC_P4,
        UPC_SDONE,
        UPC_C0,
        UPC_C1,
        UPC_C2,
        UPC_C3,
        UPC_C4,
        UPC_C5,
        UPC_C6
    } t_upc;

    // s-box address sources
    typedef enum logic [1:0] {
        ASEL_I,
        ASEL_I1,
        ASEL_J,
        ASEL_T
    } t_asel;

    // s-box write data sources
    typedef enum logic [1:0] {
        DSEL_I,
        DSEL_RD,
        DSEL_A
    } t_dsel;

    // j register operations
    typedef enum logic [1:0] {
        JOP_NONE,
        JOP_ADD,
        JOP_KEY
    } t_jop;

    // i register operations
    typedef enum logic [1:0] {
        IOP_NONE,
        IOP_INC,
        IOP_CLR
    } t_iop;

    // sequencer branch kinds
    typedef enum logic [1:0] {
        BR_NEXT,
        BR_LOOP,
        BR_IDLE
    } t_br;

    // one control word
    typedef struct packed {
        t_asel raddr;
        logic  we;
        t_asel waddr;
        t_dsel wdata;
        t_iop  iop;
        t_jop  jop;
        logic  ld_a;
        logic  ld_b;
        logic  kadv;
        logic  set_keyed;
        logic  emit;
        logic  emit_xor;
        t_br   br;
        t_upc  target;
    } t_uword;

    // control store: reset fill, key schedule, crypt step
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = '0;
        w.br = BR_NEXT;
        case (pc)
            UPC_IDLE: begin
                w.br = BR_IDLE;
            end
            UPC_RFILL: begin
                w.we = 1'b1; w.waddr = ASEL_I; w.wdata = DSEL_I;
                w.iop = IOP_INC; w.br = BR_LOOP; w.target = UPC_RFILL;
            end
            UPC_RDONE: begin
                w.br = BR_IDLE;
            end
            UPC_SCLR: begin
                w.iop = IOP_CLR;
            end
            UPC_SFILL: begin
                w.we = 1'b1; w.waddr = ASEL_I; w.wdata = DSEL_I;
                w.iop = IOP_INC; w.br = BR_LOOP; w.target = UPC_SFILL;
            end
            UPC_P0: begin
                w.raddr = ASEL_I;
            end
            UPC_P1: begin
                w.jop = JOP_KEY; w.ld_a = 1'b1;
            end
            UPC_P2: begin
                w.raddr = ASEL_J;
            end
            UPC_P3: begin
                w.we = 1'b1; w.waddr = ASEL_I; w.wdata = DSEL_RD;
            end
            UPC_P4: begin
                w.we = 1'b1; w.waddr = ASEL_J; w.wdata = DSEL_A;
                w.iop = IOP_INC; w.kadv = 1'b1;
                w.br = BR_LOOP; w.target = UPC_P0;
            end
            UPC_SDONE: begin
                w.iop = IOP_CLR; w.set_keyed = 1'b1; w.emit = 1'b1;
                w.br = BR_IDLE;
            end
            UPC_C0: begin
                w.raddr = ASEL_I1; w.iop = IOP_INC;
            end
            UPC_C1: begin
                w.jop = JOP_ADD; w.ld_a = 1'b1;
            end
            UPC_C2: begin
                w.raddr = ASEL_J;
            end
            UPC_C3: begin
                w.we = 1'b1; w.waddr = ASEL_I; w.wdata = DSEL_RD; w.ld_b = 1'b1;
            end
            UPC_C4: begin
                w.we = 1'b1; w.waddr = ASEL_J; w.wdata = DSEL_A;
            end
            UPC_C5: begin
                w.raddr = ASEL_T;
            end
            UPC_C6: begin
                w.emit = 1'b1; w.emit_xor = 1'b1; w.br = BR_IDLE;
            end
            default: begin
                w.br = BR_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/rc4_ram.sv @@
// generic simple dual-port ram with registered read
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rc4_stream_cipher.sv @@
// rc4 engine: microcoded sequencer over an s-box ram and a key store ram
// result strobe: registered straight from the request for a key load, after steps UPC_C0 to UPC_C6
//   for crypt, after the fill and permute loops for key schedule; no new request is taken while busy
// reset: synchronous, active low; afterwards busy stays high while the s-box is
//   filled with the identity, key length returns to 16 and keyed to 0
// results cannot be stalled by the receiver
module rc4_stream_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_key_index,
    input  logic [7:0] i_data_in,
    output logic       o_done,
    output logic [7:0] o_data_out,
    output logic       o_keyed,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data
);

    import rc4_pkg::*;

    t_upc              r_pc, n_pc;
    t_uword            uw;
    logic [BYTE_W-1:0] r_i, n_i;
    logic [BYTE_W-1:0] r_j, n_j;
    logic [BYTE_W-1:0] r_kidx, n_kidx;
    logic [BYTE_W-1:0] r_a, n_a;
    logic [BYTE_W-1:0] r_b, n_b;
    logic [BYTE_W-1:0] r_din, n_din;
    logic [BYTE_W-1:0] r_data_out, n_data_out;
    logic [LEN_W-1:0]  r_key_length, n_key_length;
    logic              r_keyed, n_keyed;
    logic              r_done, n_done;

    logic              accept;
    t_opcode           op;
    logic [BYTE_W-1:0] sb_raddr, sb_waddr, sb_wdata, sb_rdata;
    logic [BYTE_W-1:0] key_rdata;
    logic [BYTE_W-1:0] t_addr;
    logic [LEN_W-1:0]  kidx_inc;

    assign busy        = (r_pc != UPC_IDLE);
    assign accept      = i_rst_n && start && !busy;
    assign op          = t_opcode'(i_opcode);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_data_out  = r_data_out;
    assign o_keyed     = r_keyed;

    // control word for the current step
    always_comb begin
        uw = ucode(r_pc);
    end

    // next step: dispatch from idle, loops on the i counter
    always_comb begin
        n_pc = r_pc;
        case (uw.br)
            BR_NEXT: n_pc = t_upc'(r_pc + 5'd1);
            BR_LOOP: n_pc = (r_i != SB_LAST) ? uw.target : t_upc'(r_pc + 5'd1);
            BR_IDLE: n_pc = UPC_IDLE;
            default: n_pc = UPC_IDLE;
        endcase
        if (r_pc == UPC_IDLE) begin
            n_pc = UPC_IDLE;
            if (accept) begin
                case (op)
                    OP_SCHED: n_pc = UPC_SCLR;
                    OP_CRYPT: n_pc = UPC_C0;
                    default:  n_pc = UPC_IDLE;
                endcase
            end
        end
    end

    // s-box address and data selection
    assign t_addr = r_a + r_b;

    always_comb begin
        case (uw.raddr)
            ASEL_I:  sb_raddr = r_i;
            ASEL_I1: sb_raddr = r_i + 8'd1;
            ASEL_J:  sb_raddr = r_j;
            ASEL_T:  sb_raddr = t_addr;
            default: sb_raddr = r_i;
        endcase
        case (uw.waddr)
            ASEL_J:  sb_waddr = r_j;
            default: sb_waddr = r_i;
        endcase
        case (uw.wdata)
            DSEL_I:  sb_wdata = r_i;
            DSEL_RD: sb_wdata = sb_rdata;
            DSEL_A:  sb_wdata = r_a;
            default: sb_wdata = r_i;
        endcase
    end

    // key index wraps at the key length; zero length behaves as one
    assign kidx_inc = {1'b0, r_kidx} + 9'd1;

    // datapath register updates
    always_comb begin
        n_i          = r_i;
        n_j          = r_j;
        n_kidx       = r_kidx;
        n_a          = uw.ld_a ? sb_rdata : r_a;
        n_b          = uw.ld_b ? sb_rdata : r_b;
        n_din        = accept ? i_data_in : r_din;
        n_key_length = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_key_length;
        n_keyed      = uw.set_keyed ? 1'b1 : r_keyed;
        n_done       = 1'b0;
        n_data_out   = r_data_out;
        case (uw.iop)
            IOP_INC: n_i = r_i + 8'd1;
            IOP_CLR: begin
                n_i    = '0;
                n_j    = '0;
                n_kidx = '0;
            end
            default: n_i = r_i;
        endcase
        case (uw.jop)
            JOP_ADD: n_j = r_j + sb_rdata;
            JOP_KEY: n_j = r_j + sb_rdata + key_rdata;
            default: ;
        endcase
        if (uw.kadv) begin
            n_kidx = (kidx_inc >= r_key_length) ? '0 : kidx_inc[BYTE_W-1:0];
        end
        // result strobe: end of schedule or crypt, or an accepted request with no program (key load, unused opcode)
        if (uw.emit) begin
            n_done     = 1'b1;
            n_data_out = uw.emit_xor ? (r_din ^ sb_rdata) : '0;
        end else if (accept && op != OP_SCHED && op != OP_CRYPT) begin
            n_done     = 1'b1;
            n_data_out = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= UPC_RFILL;
            r_i          <= '0;
            r_j          <= '0;
            r_kidx       <= '0;
            r_key_length <= KEY_LEN_RESET;
            r_keyed      <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_pc         <= n_pc;
            r_i          <= n_i;
            r_j          <= n_j;
            r_kidx       <= n_kidx;
            r_key_length <= n_key_length;
            r_keyed      <= n_keyed;
            r_done       <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_din      <= n_din;
        r_data_out <= n_data_out;
    end

    // s-box memory
    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (uw.we),
        .i_waddr (sb_waddr),
        .i_wdata (sb_wdata),
        .i_raddr (sb_raddr),
        .o_rdata (sb_rdata)
    );

    // key store memory, written by load requests
    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (accept && op == OP_LOAD),
        .i_waddr (i_key_index),
        .i_wdata (i_data_in),
        .i_raddr (r_kidx),
        .o_rdata (key_rdata)
    );

endmodule

@@ hdl/rc4_checker.sv @@
// port-level checker for the rc4 engine and its bind
`include "rc4_stream_cipher_macros.svh"

module rc4_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_opcode,
    input logic       o_done,
    input logic [7:0] o_data_out,
    input logic       o_keyed
);

    import rc4_pkg::*;

    logic load_req;

    // key load request taken on the ports
    assign load_req = start && !busy && i_opcode == OP_LOAD;

    // an accepted request either answers at once or keeps the engine busy
    `RC4_ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, start && !busy, o_done || busy)

    // a key load answers in the next cycle with a zero byte
    `RC4_ASSERT_NXT(a_load_result, i_clk, i_rst_n, load_req, o_done && o_data_out == 8'd0)

    // keyed only rises together with a schedule result
    `RC4_ASSERT_IMP(a_keyed_with_done, i_clk, i_rst_n, $past(i_rst_n) && $rose(o_keyed), o_done)

    // keyed never drops outside reset
    `RC4_ASSERT_IMP(a_keyed_sticky, i_clk, i_rst_n, $past(i_rst_n) && $past(o_keyed), o_keyed)

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);
